// ===== hdl/sct_pkg.sv =====
// Shared types and constants for the sparse coordinate table.
package sct_pkg;

    localparam int MAX_DIM  = 256;
    localparam int CAPACITY = 64;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int VALUE_W = 64;
    localparam int CFG_IDX_W = 1;

    // magnitude bits of a double, sign excluded
    localparam logic [VALUE_W-1:0] MAG_MASK = {1'b0, {(VALUE_W-1){1'b1}}};

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(3);

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_RANGE     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                 command;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [VALUE_W-1:0]   value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   read_value;
        logic                 found;
        logic [CNT_W-1:0]     entry_count;
        status_t              status;
    } rsp_t;

    typedef struct packed {
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [VALUE_W-1:0]   value;
    } slot_t;

    typedef struct packed {
        logic [DIM_W-1:0]     rows;
        logic [DIM_W-1:0]     cols;
    } bounds_t;

endpackage

// ===== hdl/sct_slot_mem.sv =====
// Slot storage: coordinate and value per slot, one write and one registered read port.
module sct_slot_mem (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [sct_pkg::IDX_W-1:0] wr_addr,
    input  sct_pkg::slot_t         wr_data,
    input  logic                   rd_en,
    input  logic [sct_pkg::IDX_W-1:0] rd_addr,
    output sct_pkg::slot_t         rd_data
);
    import sct_pkg::*;

    slot_t mem [CAPACITY];
    slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sct_ctrl.sv =====
// Command sequencer: slot scan with a shared coordinate compare, valid bits, count, result word.
module sct_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sct_pkg::bounds_t          bounds,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  sct_pkg::req_t             s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output sct_pkg::rsp_t             m_data,
    output logic                      mem_wr_en,
    output logic [sct_pkg::IDX_W-1:0] mem_wr_addr,
    output sct_pkg::slot_t            mem_wr_data,
    output logic                      mem_rd_en,
    output logic [sct_pkg::IDX_W-1:0] mem_rd_addr,
    input  sct_pkg::slot_t            mem_rd_data
);
    import sct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    rsp_t                  out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CAPACITY-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W:0]        idx_reg, idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;

    logic in_range;
    logic hit;
    logic last;
    logic zero_val;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign in_range = ({1'b0, s_data.row} < bounds.rows) && (32'(s_data.row) < 32'(MAX_DIM))
                   && ({1'b0, s_data.col} < bounds.cols) && (32'(s_data.col) < 32'(MAX_DIM));

    assign mem_rd_en   = (state_reg == S_SCAN) && (idx_reg < (IDX_W+1)'(CAPACITY));
    assign mem_rd_addr = idx_reg[IDX_W-1:0];

    // compare works on the registered read data, in the cycle after the read
    assign hit  = cmp_vld_reg && valid_reg[cmp_idx_reg]
               && (mem_rd_data.row == req_reg.row) && (mem_rd_data.col == req_reg.col);
    assign last = cmp_vld_reg && (cmp_idx_reg == IDX_W'(CAPACITY - 1));
    assign zero_val = ((req_reg.value & MAG_MASK) == '0);

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = idx_reg[IDX_W-1:0];
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cmp_idx_reg;
        mem_wr_data     = '{row: req_reg.row, col: req_reg.col, value: req_reg.value};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    out_next = '{read_value: '0, found: 1'b0,
                                 entry_count: count_reg, status: STATUS_OK};
                    if (s_data.command == CMD_CLEAR) begin
                        valid_next           = '0;
                        count_next           = '0;
                        out_next.entry_count = '0;
                        m_valid_next         = 1'b1;
                        state_next           = S_RESP;
                    end else if (!in_range) begin
                        out_next.status = STATUS_RANGE;
                        m_valid_next    = 1'b1;
                        state_next      = S_RESP;
                    end else begin
                        idx_next        = '0;
                        free_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (mem_rd_en) begin
                    idx_next     = idx_reg + (IDX_W+1)'(1);
                    cmp_vld_next = 1'b1;
                    if (!valid_reg[idx_reg[IDX_W-1:0]] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg[IDX_W-1:0];
                    end
                end
                if (hit || last) begin
                    cmp_vld_next   = 1'b0;
                    out_next.found = hit;
                    unique case (req_reg.command)
                        CMD_WRITE: begin
                            if (zero_val) begin
                                if (hit) begin
                                    valid_next[cmp_idx_reg] = 1'b0;
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end else if (hit) begin
                                mem_wr_en = 1'b1;
                            end else if (free_found_reg) begin
                                mem_wr_en                = 1'b1;
                                mem_wr_addr              = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                out_next.status = STATUS_FULL;
                            end
                        end
                        CMD_READ: begin
                            if (hit) begin
                                out_next.read_value = mem_rd_data.value;
                            end
                        end
                        CMD_REMOVE: begin
                            if (hit) begin
                                valid_next[cmp_idx_reg] = 1'b0;
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                out_next.status = STATUS_NOT_FOUND;
                            end
                        end
                        CMD_CLEAR: begin
                            // handled at accept
                        end
                    endcase
                    out_next.entry_count = count_next;
                    m_valid_next         = 1'b1;
                    state_next           = S_RESP;
                end
            end
            S_RESP: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
        req_reg        <= req_next;
        out_reg        <= out_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
    end

endmodule

// ===== hdl/sparse_coordinate_table.sv =====
// Top level of the sparse coordinate table: config registers, sequencer and slot memory.
//
//  channel  | handshake           | word
//  ---------+---------------------+-------------------------------------------
//  s_       | s_valid / s_ready   | req_t: command, row, col, value
//  m_       | m_valid / m_ready   | rsp_t: read_value, found, entry_count, status
//  cfg_     | cfg_we (no wait)    | cfg_index selects rows (0) or cols (1)
//
// One word at a time. Clear and out-of-range words give a result the cycle
// after accept. Write, read and remove scan the slot memory one slot per
// cycle through a single read port and one coordinate compare, stopping at
// the first match or at the last slot.
// Synchronous active-low reset empties the table at once: slot valid bits
// are flip-flops, so no clearing pass; rows and cols go to 3.
// s_ready stays low from accept until the result word is taken; a stalled
// result holds its word.
module sparse_coordinate_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sct_pkg::req_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sct_pkg::rsp_t                 m_data,
    input  logic                          cfg_we,
    input  logic [sct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sct_pkg::DIM_W-1:0]     cfg_data
);
    import sct_pkg::*;

    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    bounds_t          bounds;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    slot_t            mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    slot_t            mem_rd_data;

    // matrix dimensions; the user is to write them only while idle (not enforced here)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROWS: rows_reg <= cfg_data;
                REG_COLS: cols_reg <= cfg_data;
            endcase
        end
    end

    assign bounds = '{rows: rows_reg, cols: cols_reg};

    sct_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bounds      (bounds),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // slot coordinates and values; only read through a set valid bit
    sct_slot_mem u_slot_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== hdl/sct_checker.sv =====
// Port-level checks for the sparse coordinate table, bound to the top level.
module sct_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input sct_pkg::rsp_t m_data
);
    import sct_pkg::*;

    // stalled result word holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one word in flight: no new accept while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    a_range_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_RANGE)
        |-> !m_data.found && (m_data.read_value == '0))
        else $error("rejected coordinate reported data");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.entry_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

endmodule

bind sparse_coordinate_table sct_checker u_sct_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
